// ----- rtl/core/lrufr_pkg.sv -----
// Shared types and constants for the LRU frame replacer.
`default_nettype none
package lrufr_pkg;

  localparam int unsigned FRAMES_DEFAULT = 64;
  localparam int unsigned FIDW           = 6;
  localparam int unsigned CNTW_OUT       = 7;
  localparam logic [6:0]  CAPACITY_RESET = 7'd64;

  typedef enum logic [1:0] {
    REQ_VICTIM = 2'd0,
    REQ_PIN    = 2'd1,
    REQ_UNPIN  = 2'd2,
    REQ_NOP    = 2'd3
  } req_type_e;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_NONE     = 1'b1
  } reg_index_e;

  // Control broadcast to every cell of the chain at once.
  typedef struct packed {
    logic            shift_all;  // victim: every cell takes its younger neighbor
    logic            pin_en;     // pin: matching cell and younger ones shift down
    logic            push_en;    // unpin: first empty cell loads the frame id
    logic [FIDW-1:0] fid;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/lrufr_cell.sv -----
// One list slot of the replacer chain: a frame id and an occupied bit.
`default_nettype none
module lrufr_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  lrufr_pkg::cell_ctrl_t                ctrl_i,
  input  logic                                 nxt_valid_i,
  input  logic [lrufr_pkg::FIDW-1:0]           nxt_id_i,
  input  logic                                 prv_valid_i,
  input  logic                                 match_i,
  output logic                                 match_o,
  output logic                                 valid_o,
  output logic [lrufr_pkg::FIDW-1:0]           id_o
);
  import lrufr_pkg::*;

  logic            valid_q, valid_d;
  logic [FIDW-1:0] id_q, id_d;
  logic            own_match;
  logic            shift;
  logic            load;

  assign own_match = ctrl_i.pin_en && valid_q && (id_q == ctrl_i.fid);
  assign match_o   = match_i || own_match;
  assign shift     = ctrl_i.shift_all || match_o;
  assign load      = ctrl_i.push_en && !valid_q && prv_valid_i;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    if (shift) begin
      valid_d = nxt_valid_i;
      id_d    = nxt_id_i;
    end else if (load) begin
      valid_d = 1'b1;
      id_d    = ctrl_i.fid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;

endmodule
`default_nettype wire

// ----- rtl/core/lru_frame_replacer.sv -----
// Top level of the LRU frame replacer: cell chain, membership bits, count, APB register.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/tready         tuser: req_type, tdata: frame_no
//   m_axis    out  m_axis_tvalid/tready         tuser: victim_found, unpin_refused
//                                               tdata: victim_frame, listed_count
//   apb       in   psel/penable/pwrite, pready  capacity at byte address 0
//
// For each request, the whole chain of cells updates at the edge that
// accepts the request, and the result lands in the output register.
// The pin shift ripples a match flag from the oldest cell to the youngest.
// A new request is taken while the output register is empty or being drained.
// Reset clears the occupied bit of every cell, all membership bits and the
// count; capacity returns to 64. No clearing pass is needed.
`default_nettype none
module lru_frame_replacer #(
  parameter int unsigned FRAMES = lrufr_pkg::FRAMES_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] frame_no, [7:6] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  // result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] victim_frame, [12:6] listed_count, [15:13] zero
  output logic [1:0]  m_axis_tuser,   // [0] victim_found, [1] unpin_refused
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lrufr_pkg::*;

  localparam int unsigned IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW   = $clog2(FRAMES + 1);
  localparam int unsigned XW   = (CW > FIDW) ? CW : FIDW;
  localparam int unsigned MW   = (CW > CNTW_OUT) ? CW : CNTW_OUT;

  // ---------------------------------------------------------------- APB
  logic [6:0] capacity_q;
  reg_index_e reg_sel;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_wr && (reg_sel == REG_CAPACITY)) begin
      capacity_q <= pwdata[6:0];
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CAPACITY: prdata = {25'd0, capacity_q};
      default:      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- request decode
  logic            req_acc;
  req_type_e       req;
  logic [FIDW-1:0] fid;
  logic [XW-1:0]   fid_x;
  logic            fid_ok;
  logic [IDXW-1:0] fid_idx;

  assign req_acc = s_axis_tvalid && s_axis_tready;
  assign req     = req_type_e'(s_axis_tuser);
  assign fid     = s_axis_tdata[FIDW-1:0];
  assign fid_x   = XW'(fid);
  assign fid_ok  = (fid_x < XW'(FRAMES));
  assign fid_idx = fid_x[IDXW-1:0];

  // ---------------------------------------------------------------- state
  logic [FRAMES-1:0] listed_q, listed_d;
  logic [CW-1:0]     count_q, count_d;
  logic              full;
  logic              is_listed;

  assign full      = (MW'(count_q) >= MW'(capacity_q));
  assign is_listed = fid_ok && listed_q[fid_idx];

  // ---------------------------------------------------------------- cell chain
  cell_ctrl_t      ctrl;
  logic            valid_w [FRAMES];
  logic [FIDW-1:0] id_w    [FRAMES];
  logic            match_w [FRAMES+1];

  assign match_w[0] = 1'b0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic            nxt_valid;
    logic [FIDW-1:0] nxt_id;
    logic            prv_valid;

    if (i == FRAMES - 1) begin : g_tail
      assign nxt_valid = 1'b0;
      assign nxt_id    = '0;
    end else begin : g_body
      assign nxt_valid = valid_w[i+1];
      assign nxt_id    = id_w[i+1];
    end

    if (i == 0) begin : g_head
      assign prv_valid = 1'b1;
    end else begin : g_link
      assign prv_valid = valid_w[i-1];
    end

    lrufr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .nxt_valid_i (nxt_valid),
      .nxt_id_i    (nxt_id),
      .prv_valid_i (prv_valid),
      .match_i     (match_w[i]),
      .match_o     (match_w[i+1]),
      .valid_o     (valid_w[i]),
      .id_o        (id_w[i])
    );
  end

  // Oldest entry sits in cell 0; its id indexes the membership bits on eviction.
  logic [XW-1:0]   head_x;
  logic [IDXW-1:0] head_idx;

  assign head_x   = XW'(id_w[0]);
  assign head_idx = head_x[IDXW-1:0];

  // ---------------------------------------------------------------- next state
  logic            found_d, refused_d;
  logic [FIDW-1:0] vframe_d;

  always_comb begin
    ctrl      = '0;
    ctrl.fid  = fid;
    listed_d  = listed_q;
    count_d   = count_q;
    found_d   = 1'b0;
    refused_d = 1'b0;
    vframe_d  = '0;
    if (req_acc) begin
      case (req)
        REQ_VICTIM: begin
          if (count_q != '0) begin
            ctrl.shift_all     = 1'b1;
            found_d            = 1'b1;
            vframe_d           = id_w[0];
            listed_d[head_idx] = 1'b0;
            count_d            = count_q - CW'(1);
          end
        end
        REQ_PIN: begin
          // Drop the frame and close the gap behind it.
          if (is_listed) begin
            ctrl.pin_en       = 1'b1;
            listed_d[fid_idx] = 1'b0;
            count_d           = count_q - CW'(1);
          end
        end
        REQ_UNPIN: begin
          // Capacity check wins over the already-listed check.
          if (fid_ok) begin
            if (full) begin
              refused_d = 1'b1;
            end else if (!is_listed) begin
              ctrl.push_en      = 1'b1;
              listed_d[fid_idx] = 1'b1;
              count_d           = count_q + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      listed_q <= '0;
      count_q  <= '0;
    end else begin
      listed_q <= listed_d;
      count_q  <= count_d;
    end
  end

  // ---------------------------------------------------------------- result register
  logic                out_valid_q;
  logic                found_q, refused_q;
  logic [FIDW-1:0]     vframe_q;
  logic [CNTW_OUT-1:0] lcount_q;

  // Take a new request while no result is held, or whenever the held result leaves in this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      found_q   <= found_d;
      refused_q <= refused_d;
      vframe_q  <= vframe_d;
      lcount_q  <= CNTW_OUT'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, lcount_q, vframe_q};
  assign m_axis_tuser  = {refused_q, found_q};

endmodule
`default_nettype wire

// ----- sim/tb_lru_frame_replacer.sv -----
// Self-checking testbench for the LRU frame replacer: stream stimulus, APB setup, result check.
module tb_lru_frame_replacer;
  timeunit 1ns;
  timeprecision 1ps;

  import lrufr_pkg::*;

  // Generous cycle limit; the slowest legal run stays well below it.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  typedef struct {
    req_type_e       kind;
    logic [FIDW-1:0] frame;
  } frame_req_t;

  typedef struct {
    logic                victim_found;
    logic [FIDW-1:0]     victim_frame;
    logic                unpin_refused;
    logic [CNTW_OUT-1:0] listed_count;
  } replace_outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // [5:0] frame_no, [7:6] zero
  logic [1:0]  s_axis_tuser = '0;     // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [5:0] victim_frame, [12:6] listed_count, [15:13] zero
  logic [1:0]  m_axis_tuser;          // [0] victim_found, [1] unpin_refused
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lru_frame_replacer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: LRU order (oldest at the front), membership bits, capacity.
  logic [FIDW-1:0]     lru_order[$];
  logic                in_list[FRAMES_DEFAULT];
  logic [CNTW_OUT-1:0] cap_limit = CAPACITY_RESET;

  frame_req_t       req_backlog[$];   // requests waiting for the driver
  replace_outcome_t outcome_due[$];   // predicted results, oldest first

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          sender_idle_on = 1'b0;
  bit          sink_idle_on = 1'b0;
  int unsigned hold_off_ticket = 0;

  initial begin
    foreach (in_list[i]) in_list[i] = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 93) return $urandom_range(3, 6);
    return $urandom_range(20, 60);
  endfunction

  // Advance the shadow state by one request and return the result it yields.
  function automatic replace_outcome_t apply_request(input frame_req_t rq);
    replace_outcome_t res;
    res = '{1'b0, '0, 1'b0, '0};
    case (rq.kind)
      REQ_VICTIM: begin
        if (lru_order.size() > 0) begin
          res.victim_frame = lru_order.pop_front();
          res.victim_found = 1'b1;
          in_list[res.victim_frame] = 1'b0;
        end
      end
      REQ_PIN: begin
        if (in_list[rq.frame]) begin
          foreach (lru_order[i]) begin
            if (lru_order[i] == rq.frame) begin
              lru_order.delete(i);
              break;
            end
          end
          in_list[rq.frame] = 1'b0;
        end
      end
      REQ_UNPIN: begin
        // Capacity test comes first, even for a frame that is already listed.
        if (lru_order.size() >= cap_limit) begin
          res.unpin_refused = 1'b1;
        end else if (!in_list[rq.frame] && lru_order.size() < FRAMES_DEFAULT) begin
          lru_order.push_back(rq.frame);
          in_list[rq.frame] = 1'b1;
        end
      end
      default: ;  // unused code: no-op that only reports the count
    endcase
    res.listed_count = CNTW_OUT'(lru_order.size());
    return res;
  endfunction

  // Driver: hold each request until accepted, then present the next one or idle.
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    frame_req_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        outcome_due.push_back(apply_request('{req_type_e'(s_axis_tuser), s_axis_tdata[5:0]}));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          nxt = req_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.kind;
          s_axis_tdata  <= {2'b00, nxt.frame};
          if (sender_idle_on && $urandom_range(0, 99) < 25) send_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction, then pick tready.
  int unsigned sink_stall = 0;
  int unsigned sink_hold = 0;
  int unsigned hold_off_seen = 0;
  always @(posedge clk_i) begin
    replace_outcome_t want;
    logic ready_next;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_due.size() == 0) begin
          report_mismatch("unexpected result, listed_count", m_axis_tdata[12:6], 0);
        end else begin
          want = outcome_due.pop_front();
          if (m_axis_tuser[0] !== want.victim_found)
            report_mismatch("victim_found", m_axis_tuser[0], want.victim_found);
          if (m_axis_tdata[5:0] !== want.victim_frame)
            report_mismatch("victim_frame", m_axis_tdata[5:0], want.victim_frame);
          if (m_axis_tuser[1] !== want.unpin_refused)
            report_mismatch("unpin_refused", m_axis_tuser[1], want.unpin_refused);
          if (m_axis_tdata[12:6] !== want.listed_count)
            report_mismatch("listed_count", m_axis_tdata[12:6], want.listed_count);
        end
      end
      // A new ticket starts a long hold-off so the block backs up into its input.
      if (hold_off_ticket != hold_off_seen) begin
        hold_off_seen = hold_off_ticket;
        sink_hold = HOLD_OFF_CYCLES;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        ready_next = 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if (sink_idle_on && $urandom_range(0, 99) < 20) sink_stall = pick_gap();
      end
      m_axis_tready <= ready_next;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_req(input req_type_e kind, input int unsigned id);
    req_backlog.push_back('{kind, FIDW'(id)});
  endtask

  // Wait until the driver has nothing left and every predicted result has come back.
  task automatic drain_results();
    do @(negedge clk_i);
    while (req_backlog.size() > 0 || s_axis_tvalid || outcome_due.size() > 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Write capacity over APB (setup, access), then read it back.
  task automatic set_capacity(input logic [CNTW_OUT-1:0] cap);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * REG_CAPACITY);
    pwdata  <= {25'd0, cap};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cap_limit = cap;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== {25'd0, cap}) report_mismatch("capacity readback", prdata, cap);
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Queue one random phase with the given mix of unpin, victim and pin weights.
  task automatic queue_phase(input int unsigned n, input int unsigned uw,
                             input int unsigned vw, input int unsigned pw,
                             input int unsigned id_max);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < uw)                add_req(REQ_UNPIN, $urandom_range(0, id_max));
      else if (r < uw + vw)      add_req(REQ_VICTIM, $urandom_range(0, 63));
      else if (r < uw + vw + pw) add_req(REQ_PIN, $urandom_range(0, id_max));
      else                       add_req(REQ_NOP, $urandom_range(0, 63));
    end
  endtask

  initial begin
    logic [CNTW_OUT-1:0] cap_plan[12];
    int unsigned mix;
    cap_plan = '{7'd64, 7'd64, 7'd0, 7'd1, 7'd63, 7'd64, 7'd2, 7'd64, 7'd32, 7'd64, 7'd5, 7'd64};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty victim, pin of an unlisted frame, repeat unpin, unused code.
    add_req(REQ_VICTIM, 63);
    add_req(REQ_PIN, 0);
    add_req(REQ_UNPIN, 0);
    add_req(REQ_UNPIN, 63);
    add_req(REQ_UNPIN, 0);
    add_req(REQ_NOP, 21);
    add_req(REQ_PIN, 63);
    add_req(REQ_UNPIN, 42);
    add_req(REQ_UNPIN, 5);
    add_req(REQ_VICTIM, 0);
    add_req(REQ_VICTIM, 0);
    add_req(REQ_VICTIM, 0);
    drain_results();

    // Small capacity: refuse when full, even for a listed frame.
    set_capacity(7'd2);
    add_req(REQ_UNPIN, 1);
    add_req(REQ_UNPIN, 2);
    add_req(REQ_UNPIN, 3);
    add_req(REQ_UNPIN, 1);
    add_req(REQ_VICTIM, 0);
    add_req(REQ_UNPIN, 3);
    drain_results();

    set_capacity(7'd0);
    add_req(REQ_UNPIN, 7);
    add_req(REQ_VICTIM, 0);
    drain_results();

    // Capacity lowered below the count: entries stay, unpins refused until it drops.
    set_capacity(7'd64);
    add_req(REQ_UNPIN, 10);
    add_req(REQ_UNPIN, 11);
    add_req(REQ_UNPIN, 12);
    drain_results();
    set_capacity(7'd1);
    add_req(REQ_UNPIN, 13);
    add_req(REQ_PIN, 11);
    add_req(REQ_VICTIM, 0);
    add_req(REQ_VICTIM, 0);
    add_req(REQ_UNPIN, 13);
    drain_results();

    // Random phases: fill-heavy, drain-heavy and balanced mixes under various capacities.
    for (int p = 0; p < 12; p++) begin
      set_capacity(cap_plan[p] == 7'd32 ? 7'($urandom_range(2, 62)) : cap_plan[p]);
      sender_idle_on = (p % 3 != 0);
      sink_idle_on   = (p % 4 != 1);
      if (p == 2 || p == 7) hold_off_ticket++;
      mix = p % 3;
      if (mix == 0)      queue_phase(150, 60, 20, 15, 63);
      else if (mix == 1) queue_phase(150, 20, 50, 25, (p == 4) ? 7 : 63);
      else               queue_phase(150, 40, 30, 25, (p == 8) ? 7 : 63);
      drain_results();
    end

    repeat (10) @(negedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/lrufr_pkg.sv
rtl/core/lrufr_cell.sv
rtl/core/lru_frame_replacer.sv
sim/tb_lru_frame_replacer.sv
